// ----- hdl/mafrm_pkg.sv -----
`default_nettype none

package mafrm_pkg;

    // field widths
    localparam int STAMP_W = 32;
    localparam int FPS_W   = 24;
    localparam int TIME_W  = 32;

    // saturation limits
    localparam logic [FPS_W-1:0]  C_FPS_MAX  = {FPS_W{1'b1}};
    localparam logic [TIME_W-1:0] C_TIME_MAX = {TIME_W{1'b1}};

    // item kind carried on the input tuser
    typedef enum logic {
        MODE_START = 1'b0,
        MODE_FRAME = 1'b1
    } t_mode;

    // divider status towards its user
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- hdl/mafrm_ring.sv -----
`default_nettype none

module mafrm_ring #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/mafrm_div.sv -----
`default_nettype none

module mafrm_div
    import mafrm_pkg::*;
#(
    parameter int DVD_W = 46,
    parameter int DVS_W = 36
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output t_div_stat             o_stat,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   dvs_ext;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign dvs_ext = {1'b0, r_dvs};
    assign rem_sub = rem_sh - dvs_ext;
    assign ge      = (rem_sh >= dvs_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse after the last quotient bit
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DVD_W-2:0], ge};
                r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_dvd;

endmodule

`default_nettype wire

// ----- hdl/moving_average_frame_rate_meter_core.sv -----
// Moving-average frame-rate meter. Feed one item per event on the s_ stream:
// tuser low marks a start item, which clears the interval history and frame
// count and records its millisecond timestamp, giving no result; tuser high
// marks a frame item, which stores the interval since the previous timestamp
// (modulo 2^32) in a ring of the last WINDOW_FRAMES intervals and returns one
// item on the m_ stream with the frame rate in unsigned Q.8 frames per second
// and the mean frame time in microseconds, both truncated and saturating,
// averaged over the frames seen since the last start (at most WINDOW_FRAMES).
// A zero interval sum raises the infinite flag with fps at full scale and the
// frame time zero. How long a frame item takes is set by the shared
// one-bit-per-cycle divider (DVD_W = 42+clog2(WINDOW_FRAMES) dividend bits),
// which runs once for the rate and once for the frame time; a zero sum skips
// it. The interval ring is one synchronous RAM read and written once per
// frame item. A finished result waits in the output register while the next
// item is taken.
`default_nettype none

module moving_average_frame_rate_meter_core
    import mafrm_pkg::*;
#(
    parameter int WINDOW_FRAMES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] timestamp_ms
    input  wire logic        s_tuser,   // [0] mode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // [23:0] fps_q8, [55:24] frame_time_us
    output logic             m_tuser    // [0] fps_infinite
);

    // ring index, frame count and sum widths follow the window length
    localparam int AW         = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int CNT_W      = $clog2(WINDOW_FRAMES + 1);
    localparam int SUM_W      = STAMP_W + $clog2(WINDOW_FRAMES);
    localparam int FPS_DVD_W  = CNT_W + 18;
    localparam int TIME_DVD_W = SUM_W + 10;
    localparam int DVD_W      = (FPS_DVD_W > TIME_DVD_W) ? FPS_DVD_W : TIME_DVD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_FPS_GO,
        S_FPS_WAIT,
        S_TIME_WAIT,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [STAMP_W-1:0]   r_last_stamp;
    logic [STAMP_W-1:0]   r_interval;
    logic [AW-1:0]        r_slot;
    logic [CNT_W-1:0]     r_seen;
    logic [SUM_W-1:0]     r_sum;
    logic [FPS_W-1:0]     r_fps;
    logic [TIME_W-1:0]    r_time;
    logic                 r_inf;
    logic                 r_m_tvalid;
    logic [FPS_W-1:0]     r_o_fps;
    logic [TIME_W-1:0]    r_o_time;
    logic                 r_o_inf;

    logic                 in_accept;
    logic [STAMP_W-1:0]   ring_rdata;
    logic [STAMP_W-1:0]   old_interval;
    logic [SUM_W-1:0]     n_sum;
    logic                 ring_we;
    logic                 window_full;

    logic [DVD_W-1:0]     cnt_ext;
    logic [DVD_W-1:0]     sum_ext;
    logic [DVD_W-1:0]     fps_dvd;
    logic [DVD_W-1:0]     time_dvd;
    logic [DVD_W-1:0]     div_dvd;
    logic [SUM_W-1:0]     div_dvs;
    logic                 div_start;
    t_div_stat            div_stat;
    logic [DVD_W-1:0]     div_quot;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (r_state == S_IDLE);

    // an entry counts only once the window has wrapped; before that the slot
    // being written was never filled since the last start and reads as zero
    assign window_full  = (r_seen == CNT_W'(WINDOW_FRAMES));
    assign old_interval = window_full ? ring_rdata : '0;
    assign n_sum        = r_sum - SUM_W'(old_interval) + SUM_W'(r_interval);
    assign ring_we      = (r_state == S_UPDATE);

    // read of the slot is issued while idle, data lands in the update cycle
    mafrm_ring #(
        .DEPTH (WINDOW_FRAMES),
        .WIDTH (STAMP_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_interval),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    // x*1000 as shifts and subtracts; fps dividend is count*1000*256
    assign cnt_ext  = DVD_W'(r_seen);
    assign sum_ext  = DVD_W'(r_sum);
    assign fps_dvd  = ((cnt_ext << 10) - (cnt_ext << 4) - (cnt_ext << 3)) << 8;
    assign time_dvd = (sum_ext << 10) - (sum_ext << 4) - (sum_ext << 3);

    // first pass: rate = count*256000 / sum, second pass: time = sum*1000 / count
    assign div_dvd   = (r_state == S_FPS_GO) ? fps_dvd : time_dvd;
    assign div_dvs   = (r_state == S_FPS_GO) ? r_sum : SUM_W'(r_seen);
    assign div_start = ((r_state == S_FPS_GO) && (r_sum != '0))
                    || ((r_state == S_FPS_WAIT) && div_stat.done);

    mafrm_div #(
        .DVD_W (DVD_W),
        .DVS_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_stat     (div_stat),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_stamp <= '0;
            r_slot       <= '0;
            r_seen       <= '0;
            r_sum        <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            // the output state handles its own reload of the output register
            if (r_m_tvalid && m_tready && (r_state != S_OUT)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_last_stamp <= s_tdata;
                        if (t_mode'(s_tuser) == MODE_START) begin
                            r_slot <= '0;
                            r_seen <= '0;
                            r_sum  <= '0;
                        end else begin
                            r_interval <= s_tdata - r_last_stamp;
                            r_state    <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    r_sum <= n_sum;
                    if (r_slot == AW'(WINDOW_FRAMES - 1)) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + AW'(1);
                    end
                    if (!window_full) begin
                        r_seen <= r_seen + CNT_W'(1);
                    end
                    r_state <= S_FPS_GO;
                end
                S_FPS_GO: begin
                    if (r_sum == '0) begin
                        r_fps   <= C_FPS_MAX;
                        r_time  <= '0;
                        r_inf   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_inf   <= 1'b0;
                        r_state <= S_FPS_WAIT;
                    end
                end
                S_FPS_WAIT: begin
                    if (div_stat.done) begin
                        if (div_quot[DVD_W-1:FPS_W] != '0) begin
                            r_fps <= C_FPS_MAX;
                        end else begin
                            r_fps <= div_quot[FPS_W-1:0];
                        end
                        r_state <= S_TIME_WAIT;
                    end
                end
                S_TIME_WAIT: begin
                    if (div_stat.done) begin
                        if (div_quot[DVD_W-1:TIME_W] != '0) begin
                            r_time <= C_TIME_MAX;
                        end else begin
                            r_time <= div_quot[TIME_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // output register free, or emptied in this cycle
                    if (!r_m_tvalid || m_tready) begin
                        r_o_fps    <= r_fps;
                        r_o_time   <= r_time;
                        r_o_inf    <= r_inf;
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {r_o_time, r_o_fps};
    assign m_tuser  = r_o_inf;

    // frame count never passes the window length
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(WINDOW_FRAMES))
        else $error("frame count beyond window");

    // ring slot stays inside the window
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= AW'(WINDOW_FRAMES - 1))
        else $error("ring slot out of range");

    // divider only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // infinite flag goes with full-scale rate and zero frame time
    a_inf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[23:0] == C_FPS_MAX)
                                  && (m_tdata[55:24] == '0))
        else $error("infinite flag with inconsistent fields");

endmodule

`default_nettype wire
